### design/short_id_codec_assert.svh
// Assertion macros for the short ID codec.
// Uses the enclosing module's clock and reset; NO_ASSERTIONS removes the checks.
`ifndef SHORT_ID_CODEC_ASSERT_SVH
`define SHORT_ID_CODEC_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SIDC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("short_id_codec: check failed");
`define SIDC_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("short_id_codec: check failed across reset");
`else
`define SIDC_ASSERT(name, prop)
`define SIDC_ASSERT_RST(name, prop)
`endif
`endif

### design/sidc_pkg.sv
// Shared types and constants for the short ID codec.
// No dependencies.
package sidc_pkg;

   localparam int DEF_MAX_SYMBOLS   = 32;
   localparam int DEF_MAX_ID_LENGTH = 16;

   localparam int QUOT_W       = 64;
   localparam int CHAR_W       = 8;
   localparam int ALPHA_IDX_W  = 5;
   localparam int ALPHA_DEPTH  = 32;
   localparam int SYM_COUNT_W  = 6;
   localparam int REV_W        = 5;
   localparam int LEN_W        = 5;
   localparam int NUMBER_W     = 63;
   localparam int CSR_INDEX_W  = 3;

   // divider takes this many quotient bits per cycle
   localparam int DIV_CHUNK    = 8;
   localparam int CHUNK_COUNT  = QUOT_W / DIV_CHUNK;
   localparam int CHUNK_CNT_W  = $clog2(CHUNK_COUNT);

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_0       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_1       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_2       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_3       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_COUNT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_WIDTH = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_LENGTH     = 3'd6;

   localparam logic OP_ENCODE  = 1'b0;
   localparam logic OP_DECODE  = 1'b1;
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   localparam logic [SYM_COUNT_W-1:0] SYM_COUNT_RESET = 6'd32;
   localparam logic [LEN_W-1:0]       ID_LENGTH_RESET = 5'd8;

   typedef logic [ALPHA_DEPTH-1:0][CHAR_W-1:0] alphabet_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_EMIT = 7'b0000100,
      ST_LOOK = 7'b0001000,
      ST_ACC  = 7'b0010000,
      ST_DOUT = 7'b0100000,
      ST_HOLD = 7'b1000000
   } sidc_state_type;

   typedef struct packed {
      logic load;
      logic start;
   } sidc_div_ctl_type;

   typedef struct packed {
      logic done;
      logic nonzero;
   } sidc_div_sts_type;

   // reverse the low bs bits of x, upper bits pass
   function automatic logic [QUOT_W-1:0] flip_low(input logic [QUOT_W-1:0] x,
                                                  input logic [REV_W-1:0] bs);
      logic [QUOT_W-1:0] r;
      r = x;
      for (int j = 0; j < 32; j++) begin
         if (j < int'(bs)) begin
            r[j] = x[6'(int'(bs) - 1 - j)];
         end
      end
      return r;
   endfunction

endpackage

### design/sidc_div.sv
// Iterative divider of the short ID codec: one digit per run, eight quotient bits a cycle.
// Depends on sidc_pkg.
module sidc_div import sidc_pkg::*; #(
   parameter int DIGIT_W = 5,
   parameter int BASE_W  = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sidc_div_ctl_type       ctl,
   input  logic [QUOT_W-1:0]      load_value,
   input  logic [BASE_W-1:0]      base,
   output sidc_div_sts_type       sts,
   output logic [DIGIT_W-1:0]     digit
);

   logic [QUOT_W-1:0]      quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CHUNK_CNT_W-1:0] chunk_ff, chunk_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGIT_W-1:0]     step_rem;
   logic [DIV_CHUNK-1:0]   step_q;

   always_comb begin
      logic [BASE_W-1:0]    sh;
      logic [DIGIT_W-1:0]   r;
      logic [DIV_CHUNK-1:0] top;
      r   = rem_ff;
      top = quot_ff[QUOT_W-1 -: DIV_CHUNK];
      step_q = '0;
      for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
         sh = {r, top[k]};
         if (sh >= base) begin
            r = DIGIT_W'(sh - base);
            step_q[k] = 1'b1;
         end else begin
            r = DIGIT_W'(sh);
         end
      end
      step_rem = r;
   end

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (busy_ff) begin
         quot_in  = {quot_ff[QUOT_W-DIV_CHUNK-1:0], step_q};
         rem_in   = step_rem;
         chunk_in = chunk_ff + CHUNK_CNT_W'(1);
         if (chunk_ff == CHUNK_CNT_W'(CHUNK_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (ctl.load) begin
         quot_in = load_value;
      end
      if (ctl.start) begin
         busy_in  = 1'b1;
         rem_in   = '0;
         chunk_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         chunk_ff <= '0;
      end else begin
         quot_ff  <= quot_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         chunk_ff <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign sts.done    = done_ff;
   assign sts.nonzero = |quot_ff;
   assign digit       = rem_ff;

endmodule

### design/short_id_codec.sv
// Short ID codec: number to fixed-length base-N text ID and back.
// Encode: each digit is one run of the shared divider (8 quotient bits a cycle), then
//   one word per cycle out while the response slot is free.
// Decode: a lookup and an accumulate step per character; the final one also gives the value word.
// Reset is synchronous: registers return to their reset values; digit store is not cleared.
// Depends on sidc_pkg, sidc_div and short_id_codec_assert.svh.
`include "short_id_codec_assert.svh"
module short_id_codec import sidc_pkg::*; #(
   parameter int MAX_SYMBOLS   = DEF_MAX_SYMBOLS,
   parameter int MAX_ID_LENGTH = DEF_MAX_ID_LENGTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [NUMBER_W-1:0]    req_number,
   input  logic [CHAR_W-1:0]      req_symbol,
   input  logic                   req_final_symbol,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [CHAR_W-1:0]      rsp_text_char,
   output logic [QUOT_W-1:0]      rsp_decoded,
   output logic                   rsp_last,
   output logic                   rsp_bad,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [QUOT_W-1:0]      csr_data
);

   localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int BASE_W  = DIGIT_W + 1;
   localparam int IDX_W   = (MAX_ID_LENGTH > 1) ? $clog2(MAX_ID_LENGTH) : 1;

   alphabet_type           alpha_ff, alpha_in;
   logic [SYM_COUNT_W-1:0] sym_count_ff, sym_count_in;
   logic [REV_W-1:0]       rev_ff, rev_in;
   logic [LEN_W-1:0]       id_len_ff, id_len_in;

   sidc_state_type         state_ff, state_in;
   logic [IDX_W-1:0]       dig_ff, dig_in;
   logic [QUOT_W-1:0]      acc_ff, acc_in;
   logic                   err_ff, err_in;
   logic [CHAR_W-1:0]      sym_ff, sym_in;
   logic                   final_ff, final_in;
   logic [DIGIT_W-1:0]     idx_ff, idx_in;
   logic [DIGIT_W-1:0]     digit_ff [MAX_ID_LENGTH];
   logic                   digit_we;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [QUOT_W-1:0]      rsp_dec_ff, rsp_dec_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_bad_ff, rsp_bad_in;
   logic                   rsp_load;
   logic                   slot_free;

   logic [BASE_W-1:0]      base;
   logic [IDX_W-1:0]       last_idx;
   logic                   look_found;
   logic [DIGIT_W-1:0]     look_idx;

   sidc_div_ctl_type       div_ctl;
   sidc_div_sts_type       div_sts;
   logic [DIGIT_W-1:0]     div_digit;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      alpha_in     = alpha_ff;
      sym_count_in = sym_count_ff;
      rev_in       = rev_ff;
      id_len_in    = id_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA_0:       alpha_in[7:0]   = csr_data;
            CSR_ALPHA_1:       alpha_in[15:8]  = csr_data;
            CSR_ALPHA_2:       alpha_in[23:16] = csr_data;
            CSR_ALPHA_3:       alpha_in[31:24] = csr_data;
            CSR_SYMBOL_COUNT:  sym_count_in    = csr_data[SYM_COUNT_W-1:0];
            CSR_REVERSE_WIDTH: rev_in          = csr_data[REV_W-1:0];
            CSR_ID_LENGTH:     id_len_in       = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped base and ID length
   always_comb begin
      if (sym_count_ff < 6'd2) begin
         base = BASE_W'(2);
      end else if (sym_count_ff > SYM_COUNT_W'(MAX_SYMBOLS)) begin
         base = BASE_W'(MAX_SYMBOLS);
      end else begin
         base = BASE_W'(sym_count_ff);
      end
      if (id_len_ff == '0) begin
         last_idx = '0;
      end else if (id_len_ff > LEN_W'(MAX_ID_LENGTH)) begin
         last_idx = IDX_W'(MAX_ID_LENGTH - 1);
      end else begin
         last_idx = IDX_W'(id_len_ff - 5'd1);
      end
   end

   // alphabet lookup, highest matching index wins
   always_comb begin
      look_found = 1'b0;
      look_idx   = '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if ((BASE_W'(i) < base) && (alpha_ff[i] == sym_ff)) begin
            look_found = 1'b1;
            look_idx   = DIGIT_W'(i);
         end
      end
   end

   sidc_div #(
      .DIGIT_W (DIGIT_W),
      .BASE_W  (BASE_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .ctl        (div_ctl),
      .load_value (flip_low({1'b0, req_number}, rev_ff)),
      .base       (base),
      .sts        (div_sts),
      .digit      (div_digit)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      dig_in      = dig_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      sym_in      = sym_ff;
      final_in    = final_ff;
      idx_in      = idx_ff;
      digit_we    = 1'b0;
      div_ctl     = '0;
      rsp_load    = 1'b0;
      rsp_kind_in = KIND_CHAR;
      rsp_char_in = '0;
      rsp_dec_in  = '0;
      rsp_last_in = 1'b0;
      rsp_bad_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_ENCODE) begin
                  div_ctl.load  = 1'b1;
                  div_ctl.start = 1'b1;
                  dig_in        = '0;
                  state_in      = ST_DIV;
               end else begin
                  sym_in   = req_symbol;
                  final_in = req_final_symbol;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               digit_we = 1'b1;
               if (dig_ff == last_idx) begin
                  state_in = ST_EMIT;
               end else begin
                  dig_in        = dig_ff + IDX_W'(1);
                  div_ctl.start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_CHAR;
               rsp_char_in = alpha_ff[ALPHA_IDX_W'(digit_ff[dig_ff])];
               rsp_last_in = (dig_ff == '0);
               rsp_bad_in  = div_sts.nonzero;
               if (dig_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_in = dig_ff - IDX_W'(1);
               end
            end
         end
         ST_LOOK: begin
            idx_in   = look_idx;
            err_in   = err_ff | !look_found;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff * QUOT_W'(base) + QUOT_W'(idx_ff);
            state_in = final_ff ? ST_DOUT : ST_IDLE;
         end
         ST_DOUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_VALUE;
               rsp_dec_in  = flip_low(acc_ff, rev_ff);
               rsp_last_in = 1'b1;
               rsp_bad_in  = err_ff;
               acc_in      = '0;
               err_in      = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= '0;
         sym_count_ff <= SYM_COUNT_RESET;
         rev_ff       <= '0;
         id_len_ff    <= ID_LENGTH_RESET;
         state_ff     <= ST_IDLE;
         dig_ff       <= '0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         sym_count_ff <= sym_count_in;
         rev_ff       <= rev_in;
         id_len_ff    <= id_len_in;
         state_ff     <= state_in;
         dig_ff       <= dig_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      final_ff <= final_in;
      idx_ff   <= idx_in;
      if (digit_we) begin
         digit_ff[dig_ff] <= div_digit;
      end
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_char_ff <= rsp_char_in;
         rsp_dec_ff  <= rsp_dec_in;
         rsp_last_ff <= rsp_last_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_decoded   = rsp_dec_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad       = rsp_bad_ff;

   `SIDC_ASSERT(a_value_word_is_last, rsp_valid && rsp_kind == KIND_VALUE |-> rsp_last)
   `SIDC_ASSERT(a_div_done_in_div, div_sts.done |-> state_ff == ST_DIV)
   `SIDC_ASSERT(a_dout_clears_acc, state_ff == ST_DOUT && slot_free |=> acc_ff == '0 && !err_ff)
   `SIDC_ASSERT(a_accept_leaves_idle, req_valid && req_ready |=> state_ff != ST_IDLE)
   `SIDC_ASSERT_RST(a_reset_empties_rsp, $past(reset) |-> !rsp_valid)

endmodule

### verif/short_id_codec_tb.sv
// Testbench for short_id_codec: directed table, then randomised config phases.
// Words are predicted in-bench from the configured alphabet and checked in order.
// Depends on sidc_pkg and the short_id_codec RTL.
module short_id_codec_tb import sidc_pkg::*; ();

   localparam int CYCLE_CAP = 5_000_000;
   localparam int SETTLE    = 24;
   localparam int TAIL      = 200;
   localparam int HOLD_OFF  = 300;
   localparam int PHASES    = 8;
   localparam int PER_PHASE = 46;
   localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;

   typedef enum logic [1:0] {ROW_CSR, ROW_ITEM, ROW_PINNED} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  reg_idx;
      logic [QUOT_W-1:0]       data;
      logic                    op;
      logic [NUMBER_W-1:0]     number;
      logic [CHAR_W-1:0]       sym;
      logic                    fin;
      logic [CHAR_W-1:0]       pin_char;
      logic [QUOT_W-1:0]       pin_val;
      logic                    pin_bad;
   } plan_row_type;

   typedef struct packed {
      logic              kind;
      logic [CHAR_W-1:0] text_char;
      logic [QUOT_W-1:0] decoded;
      logic              last;
      logic              bad;
   } id_word_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_opcode;
   logic [NUMBER_W-1:0]    req_number;
   logic [CHAR_W-1:0]      req_symbol;
   logic                   req_final_symbol;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_kind;
   logic [CHAR_W-1:0]      rsp_text_char;
   logic [QUOT_W-1:0]      rsp_decoded;
   logic                   rsp_last;
   logic                   rsp_bad;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [QUOT_W-1:0]      csr_data;

   // configuration and decode state as the block should hold them
   logic [4*QUOT_W-1:0]    cfg_alpha;
   logic [SYM_COUNT_W-1:0] cfg_count;
   logic [REV_W-1:0]       cfg_rev;
   logic [LEN_W-1:0]       cfg_len;
   logic [QUOT_W-1:0]      sum_acc;
   logic                   sum_bad;

   id_word_type  step_words [DEF_MAX_ID_LENGTH];
   int           step_n;
   id_word_type  words_due [$];
   plan_row_type plan [$];

   int fail_count = 0;
   int cycle_no = 0;
   bit steady = 1'b0;
   bit squeeze_go = 1'b0;
   bit squeeze_done = 1'b0;

   int cnt_pick [PHASES] = '{1, 32, 2, 63, 0, 33, -1, -1};
   int rev_pick [PHASES] = '{0, 31, 1, 31, 0, 7, -1, -1};
   int len_pick [PHASES] = '{16, 1, 31, 0, 17, 8, -1, -1};

   short_id_codec dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_number(req_number),
      .req_symbol(req_symbol),
      .req_final_symbol(req_final_symbol),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_text_char(rsp_text_char),
      .rsp_decoded(rsp_decoded),
      .rsp_last(rsp_last),
      .rsp_bad(rsp_bad),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no > CYCLE_CAP) begin
         $display("short_id_codec_tb: FAIL");
         $finish;
      end
   end

   function automatic int base_in_use();
      if (cfg_count < 2) return 2;
      if (cfg_count > DEF_MAX_SYMBOLS) return DEF_MAX_SYMBOLS;
      return int'(cfg_count);
   endfunction

   function automatic int len_in_use();
      if (cfg_len < 1) return 1;
      if (cfg_len > DEF_MAX_ID_LENGTH) return DEF_MAX_ID_LENGTH;
      return int'(cfg_len);
   endfunction

   function automatic logic [CHAR_W-1:0] alpha_at(input int i);
      return cfg_alpha[8*i +: 8];
   endfunction

   function automatic logic [QUOT_W-1:0] reverse_low(input logic [QUOT_W-1:0] x,
                                                     input logic [REV_W-1:0] span);
      logic [QUOT_W-1:0] y;
      int k;
      y = x;
      for (k = 0; k < int'(span); k++) y[int'(span) - 1 - k] = x[k];
      return y;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [QUOT_W-1:0] data);
      case (idx)
         CSR_ALPHA_0, CSR_ALPHA_1, CSR_ALPHA_2, CSR_ALPHA_3: begin
            cfg_alpha[QUOT_W*int'(idx) +: QUOT_W] = data;
         end
         CSR_SYMBOL_COUNT: cfg_count = data[SYM_COUNT_W-1:0];
         CSR_REVERSE_WIDTH: cfg_rev = data[REV_W-1:0];
         CSR_ID_LENGTH: cfg_len = data[LEN_W-1:0];
         default: ;
      endcase
   endfunction

   // words caused by one accepted item, left in step_words
   function automatic void codec_outcome(input plan_row_type r);
      logic [QUOT_W-1:0] q;
      logic [QUOT_W-1:0] m64;
      logic [ALPHA_IDX_W-1:0] digit [DEF_MAX_ID_LENGTH];
      int m, n, i, idx;
      bit hit;
      m = base_in_use();
      n = len_in_use();
      m64 = QUOT_W'(m);
      step_n = 0;
      if (r.op == OP_ENCODE) begin
         q = reverse_low({1'b0, r.number}, cfg_rev);
         for (i = 0; i < n; i++) begin
            digit[i] = ALPHA_IDX_W'(q % m64);
            q = q / m64;
         end
         for (i = 0; i < n; i++) begin
            step_words[i] = '{KIND_CHAR, alpha_at(int'(digit[n-1-i])), '0,
                              (i == n - 1), (q != 0)};
         end
         step_n = n;
      end else begin
         idx = 0;
         hit = 1'b0;
         for (i = 0; i < m; i++) begin
            if (alpha_at(i) == r.sym) begin
               idx = i;
               hit = 1'b1;
            end
         end
         if (!hit) sum_bad = 1'b1;
         sum_acc = sum_acc * m64 + QUOT_W'(idx);
         if (r.fin) begin
            step_words[0] = '{KIND_VALUE, '0, reverse_low(sum_acc, cfg_rev), 1'b1, sum_bad};
            step_n = 1;
            sum_acc = '0;
            sum_bad = 1'b0;
         end
      end
   endfunction

   function automatic plan_row_type item_row(input logic op, input logic [NUMBER_W-1:0] num,
                                             input logic [CHAR_W-1:0] sym, input logic fin);
      plan_row_type r;
      r.kind = ROW_ITEM;
      r.reg_idx = CSR_ALPHA_0;
      r.data = '0;
      r.op = op;
      r.number = num;
      r.sym = sym;
      r.fin = fin;
      r.pin_char = '0;
      r.pin_val = '0;
      r.pin_bad = 1'b0;
      return r;
   endfunction

   function automatic void add_item(input logic op, input logic [NUMBER_W-1:0] num,
                                    input logic [CHAR_W-1:0] sym, input logic fin);
      plan.push_back(item_row(op, num, sym, fin));
   endfunction

   function automatic void add_pin(input logic op, input logic [NUMBER_W-1:0] num,
                                   input logic [CHAR_W-1:0] sym, input logic fin,
                                   input logic [CHAR_W-1:0] pchar,
                                   input logic [QUOT_W-1:0] pval, input logic pbad);
      plan_row_type r;
      r = item_row(op, num, sym, fin);
      r.kind = ROW_PINNED;
      r.pin_char = pchar;
      r.pin_val = pval;
      r.pin_bad = pbad;
      plan.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [QUOT_W-1:0] data);
      plan_row_type r;
      r = item_row(OP_ENCODE, '0, '0, 1'b0);
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.data = data;
      plan.push_back(r);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_gap();
      if (steady || $urandom_range(0, 99) < 45) return 0;
      return idle_len();
   endfunction

   function automatic void check_field(input string name, input logic [QUOT_W-1:0] want,
                                       input logic [QUOT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [QUOT_W-1:0] data);
      req_valid = 1'b0;
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
   endtask

   task automatic offer(input plan_row_type r);
      id_word_type w;
      int gap;
      csr_valid = 1'b0;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode = r.op;
      req_number = r.number;
      req_symbol = r.sym;
      req_final_symbol = r.fin;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      codec_outcome(r);
      for (int k = 0; k < step_n; k++) begin
         w = step_words[k];
         if (r.kind == ROW_PINNED) begin
            w.text_char = (w.kind == KIND_CHAR) ? r.pin_char : '0;
            w.decoded = (w.kind == KIND_VALUE) ? r.pin_val : '0;
            w.bad = r.pin_bad;
         end
         words_due.push_back(w);
      end
      @(negedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid = 1'b0;
      csr_valid = 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   always @(posedge clock) begin : result_check
      id_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (words_due.size() == 0) begin
            $error("unexpected word: kind %0d char %h decoded %h", rsp_kind, rsp_text_char,
                   rsp_decoded);
            fail_count++;
         end else begin
            want = words_due.pop_front();
            check_field("kind", QUOT_W'(want.kind), QUOT_W'(rsp_kind));
            check_field("text_char", QUOT_W'(want.text_char), QUOT_W'(rsp_text_char));
            check_field("decoded", want.decoded, rsp_decoded);
            check_field("last", QUOT_W'(want.last), QUOT_W'(rsp_last));
            check_field("bad", QUOT_W'(want.bad), QUOT_W'(rsp_bad));
         end
      end
   end

   initial begin : receiver
      int run;
      bit take;
      rsp_ready = 1'b0;
      run = 0;
      take = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_go && !squeeze_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            squeeze_done = 1'b1;
         end
         if (run == 0) begin
            take = ($urandom_range(0, 99) < 70);
            run = take ? $urandom_range(1, 40) : idle_len();
         end
         rsp_ready = take;
         run--;
      end
   end

   initial begin : stimulus
      logic [QUOT_W-1:0] word, junk;
      logic [NUMBER_W-1:0] num;
      logic [CHAR_W-1:0] sym;
      int style, stride, base_off, val, sent, span, w, pick;

      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ENCODE;
      req_number = '0;
      req_symbol = '0;
      req_final_symbol = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ALPHA_0;
      csr_data = '0;
      cfg_alpha = '0;
      cfg_count = SYM_COUNT_RESET;
      cfg_rev = '0;
      cfg_len = ID_LENGTH_RESET;
      sum_acc = '0;
      sum_bad = 1'b0;

      // reset alphabet is all zero bytes: a zero symbol matches every entry, highest index wins
      add_pin(OP_ENCODE, '0, 8'h00, 1'b0, 8'h00, '0, 1'b0);
      add_pin(OP_ENCODE, '1, 8'hFF, 1'b1, 8'h00, '0, 1'b1);
      add_pin(OP_DECODE, '0, 8'h00, 1'b1, 8'h00, 64'd31, 1'b0);
      add_pin(OP_DECODE, '1, 8'h41, 1'b1, 8'h00, '0, 1'b1);
      for (w = 0; w < 4; w++) begin
         for (int b = 0; b < 8; b++) word[8*b +: 8] = DIGIT_ZERO + CHAR_W'(8*w + b);
         add_csr(CSR_ALPHA_0 + CSR_INDEX_W'(w), word);
      end
      add_csr(CSR_SYMBOL_COUNT, 64'd0);
      add_csr(CSR_ID_LENGTH, 64'd16);
      add_pin(OP_ENCODE, '0, 8'h00, 1'b0, DIGIT_ZERO, '0, 1'b0);
      add_pin(OP_ENCODE, 63'hFFFF, 8'h00, 1'b0, DIGIT_ZERO + 8'd1, '0, 1'b0);
      add_pin(OP_ENCODE, 63'h1FFFF, 8'h00, 1'b0, DIGIT_ZERO + 8'd1, '0, 1'b1);
      add_item(OP_DECODE, '0, DIGIT_ZERO + 8'd1, 1'b0);
      add_pin(OP_DECODE, '0, DIGIT_ZERO + 8'd2, 1'b1, 8'h00, 64'd2, 1'b1);
      add_csr(CSR_SYMBOL_COUNT, 64'd63);
      add_csr(CSR_REVERSE_WIDTH, 64'd31);
      add_csr(CSR_ID_LENGTH, 64'd0);
      add_pin(OP_ENCODE, 63'd1, 8'h00, 1'b0, DIGIT_ZERO, '0, 1'b1);
      add_item(OP_DECODE, '0, DIGIT_ZERO + 8'd31, 1'b1);
      add_csr(CSR_ID_LENGTH, 64'd31);
      add_csr(CSR_SYMBOL_COUNT, 64'd33);
      add_csr(CSR_REVERSE_WIDTH, 64'd0);
      add_item(OP_ENCODE, '1, 8'h00, 1'b0);
      // thirteen top symbols wrap to all ones; an encode in the middle leaves the sum
      for (int k = 0; k < 12; k++) begin
         if (k == 6) add_pin(OP_ENCODE, '0, 8'h00, 1'b0, DIGIT_ZERO, '0, 1'b0);
         add_item(OP_DECODE, '0, DIGIT_ZERO + 8'd31, 1'b0);
      end
      add_pin(OP_DECODE, '0, DIGIT_ZERO + 8'd31, 1'b1, 8'h00, '1, 1'b0);

      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR) begin
            if (k == 0 || plan[k-1].kind != ROW_CSR) wait_idle(SETTLE);
            csr_put(plan[k].reg_idx, plan[k].data);
         end else begin
            offer(plan[k]);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle(SETTLE);
         style = $urandom_range(0, 2);
         stride = 2 * $urandom_range(0, 127) + 1;
         base_off = $urandom_range(0, 255);
         for (w = 0; w < 4; w++) begin
            for (int b = 0; b < 8; b++) begin
               case (style)
                  0: word[8*b +: 8] = CHAR_W'(base_off + (8*w + b) * stride);
                  1: word[8*b +: 8] = DIGIT_ZERO + CHAR_W'($urandom_range(0, 11));
                  default: word[8*b +: 8] = CHAR_W'($urandom);
               endcase
            end
            csr_put(CSR_ALPHA_0 + CSR_INDEX_W'(w), word);
         end
         junk = {$urandom, $urandom};
         val = (cnt_pick[ph] < 0) ? $urandom_range(2, 32) : cnt_pick[ph];
         csr_put(CSR_SYMBOL_COUNT, {junk[63:SYM_COUNT_W], SYM_COUNT_W'(val)});
         val = (rev_pick[ph] < 0) ? $urandom_range(0, 31) : rev_pick[ph];
         csr_put(CSR_REVERSE_WIDTH, {junk[63:REV_W], REV_W'(val)});
         val = (len_pick[ph] < 0) ? $urandom_range(1, 16) : len_pick[ph];
         csr_put(CSR_ID_LENGTH, {~junk[63:LEN_W], LEN_W'(val)});
         steady = (ph % 3 == 2);
         if (ph == 1) squeeze_go = 1'b1;

         sent = 0;
         while (sent < PER_PHASE) begin
            pick = $urandom_range(0, 99);
            junk = {$urandom, $urandom};
            if (pick < 35) begin
               num = junk[NUMBER_W-1:0];
               w = $urandom_range(0, 63);
               if (w < 63) num = num & ((63'd1 << w) - 63'd1);
               offer(item_row(OP_ENCODE, num, junk[7:0], junk[8]));
               sent++;
            end else if (pick < 88) begin
               span = $urandom_range(1, len_in_use() + 2);
               for (int c = 0; c < span; c++) begin
                  junk = {$urandom, $urandom};
                  if ($urandom_range(0, 9) != 0) sym = alpha_at($urandom_range(0, base_in_use() - 1));
                  else sym = junk[7:0];
                  offer(item_row(OP_DECODE, junk[NUMBER_W-1:0], sym, c == span - 1));
               end
               sent += span;
            end else begin
               offer(item_row(OP_DECODE, junk[NUMBER_W-1:0], junk[7:0], junk[9:8] == 2'b00));
               sent++;
            end
         end
      end

      wait_idle(TAIL);
      if (fail_count == 0) begin
         $display("short_id_codec_tb: PASS");
      end else begin
         $display("short_id_codec_tb: FAIL");
      end
      $finish;
   end

endmodule

### short_id_codec.f
+incdir+design
design/sidc_pkg.sv
design/sidc_div.sv
design/short_id_codec.sv
verif/short_id_codec_tb.sv
